// ===== hdl/vtp_pkg.sv =====
// Shared types, constants and a helper function for the vertex transform block.
`default_nettype none
package vtp_pkg;

    // Coefficient and vertex formats.
    localparam int COEF_W = 16;
    localparam int VERT_W = 32;
    localparam int PROD_W = COEF_W + VERT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC_COEF = 12;
    localparam int FRAC_VERT = 16;

    // Divider: one quotient bit per stage, plus an input and an output register.
    localparam int DIV_BITS = VERT_W + FRAC_VERT;
    localparam int DIV_LAT  = DIV_BITS + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0    = 3'd0,
        REG_ROW1    = 3'd1,
        REG_ROW2    = 3'd2,
        REG_ROW3    = 3'd3,
        REG_PROJECT = 3'd4
    } cfg_reg_t;

    // Matrix reset values give the identity.
    localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [63:0] ROW3_RST = 64'h1000_0000_0000_0000;

    // Clamp a sign and magnitude to the signed 32-bit range; returns {sat, value}.
    function automatic logic [VERT_W:0] clamp_pack(input logic neg,
                                                   input logic [DIV_BITS-1:0] mag);
        logic [DIV_BITS-1:0] lim;
        logic                sat;
        logic [VERT_W-1:0]   m;
        logic [VERT_W-1:0]   val;
        lim = neg ? DIV_BITS'(64'h8000_0000) : DIV_BITS'(64'h7FFF_FFFF);
        sat = (mag > lim);
        m   = sat ? lim[VERT_W-1:0] : mag[VERT_W-1:0];
        val = neg ? (~m + VERT_W'(1)) : m;
        return {sat, val};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/vtp_div.sv =====
// Pipelined restoring divider producing a saturated signed Q16.16 quotient.
`default_nettype none
module vtp_div
    import vtp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [VERT_W-1:0] num,
    input  wire logic [VERT_W-1:0] den,
    output logic                   out_valid,
    output logic [VERT_W-1:0]      quot,
    output logic                   sat
);

    logic [DIV_BITS-1:0] n_reg [0:DIV_BITS];
    logic [VERT_W-1:0]   r_reg [0:DIV_BITS];
    logic [VERT_W-1:0]   d_reg [0:DIV_BITS];
    logic                neg_reg [0:DIV_BITS];
    logic                v_reg [0:DIV_BITS];
    logic [VERT_W-1:0]   nmag;
    logic [VERT_W-1:0]   dmag;
    logic [VERT_W:0]     cp;
    logic                out_valid_reg;
    logic [VERT_W-1:0]   quot_reg;
    logic                sat_reg;

    // Magnitudes of the operands; the most negative value maps to 2^31.
    assign nmag = num[VERT_W-1] ? (~num + VERT_W'(1)) : num;
    assign dmag = den[VERT_W-1] ? (~den + VERT_W'(1)) : den;

    // Input register: numerator magnitude scaled by 2^16.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0]   <= {nmag, {FRAC_VERT{1'b0}}};
        r_reg[0]   <= '0;
        d_reg[0]   <= dmag;
        neg_reg[0] <= num[VERT_W-1] ^ den[VERT_W-1];
    end

    // One quotient bit per stage; quotient bits shift in as numerator bits leave.
    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_step
        logic [VERT_W:0]   t;
        logic              qbit;
        logic [VERT_W:0]   diff;

        always_comb
        begin
            t    = {r_reg[k], n_reg[k][DIV_BITS-1]};
            diff = t - {1'b0, d_reg[k]};
            qbit = (t >= {1'b0, d_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k+1]   <= {n_reg[k][DIV_BITS-2:0], qbit};
            r_reg[k+1]   <= qbit ? diff[VERT_W-1:0] : t[VERT_W-1:0];
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    // Output register: clamp and apply the sign.
    assign cp = clamp_pack(neg_reg[DIV_BITS], n_reg[DIV_BITS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= cp[VERT_W-1:0];
        sat_reg  <= cp[VERT_W];
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;
    assign sat       = sat_reg;

endmodule
`default_nettype wire

// ===== hdl/vertex_transform_project_core.sv =====
// Top level of the vertex transform with optional perspective divide.
`default_nettype none
// A vertex is taken on every cycle in which start is high; busy is always low.
// Each vertex produces one result, marked by done. Three stages form the
// 4x4 matrix product (sixteen parallel 16x32 multipliers, a row adder, then
// truncation and clamping). The dividers for x and for y each take 50 stages:
// an input register, 48 restoring stages that each yield one quotient bit,
// and an output register that clamps and applies the sign. One output
// register follows. Results cannot be held off by the receiver.
// Configuration writes are always ready and must only be made while no vertex
// is in flight.
module vertex_transform_project_core
    import vtp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [31:0]    vertex_x,
    input  wire logic signed [31:0]    vertex_y,
    input  wire logic signed [31:0]    vertex_z,
    input  wire logic signed [31:0]    vertex_w,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]           cfg_data,
    output logic                       done,
    output logic signed [31:0]         out_x,
    output logic signed [31:0]         out_y,
    output logic signed [31:0]         out_z,
    output logic signed [31:0]         out_w,
    output logic                       divide_skipped,
    output logic                       saturated
);

    typedef struct packed {
        logic [VERT_W-1:0] tx;
        logic [VERT_W-1:0] ty;
        logic [VERT_W-1:0] tz;
        logic [VERT_W-1:0] tw;
        logic              sat;
        logic              skip;
        logic              div;
    } side_t;

    logic [63:0]              row_reg [0:3];
    logic                     proj_reg;
    logic signed [PROD_W-1:0] p_reg [0:3][0:3];
    logic                     v1_reg;
    logic signed [SUM_W-1:0]  s_reg [0:3];
    logic                     v2_reg;
    logic [VERT_W:0]          cp [0:3];
    side_t                    s3_next;
    side_t                    s3_reg;
    logic                     v3_reg;
    side_t                    side_reg [0:DIV_LAT-1];
    logic                     sv_reg [0:DIV_LAT-1];
    logic                     qx_valid;
    logic                     qy_valid;
    logic [VERT_W-1:0]        qx;
    logic [VERT_W-1:0]        qy;
    logic                     qx_sat;
    logic                     qy_sat;
    logic                     done_reg;
    logic [VERT_W-1:0]        out_x_reg;
    logic [VERT_W-1:0]        out_y_reg;
    logic [VERT_W-1:0]        out_z_reg;
    logic [VERT_W-1:0]        out_w_reg;
    logic                     skip_reg;
    logic                     sat_reg;
    logic signed [VERT_W-1:0] vin [0:3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW0_RST;
            row_reg[1] <= ROW1_RST;
            row_reg[2] <= ROW2_RST;
            row_reg[3] <= ROW3_RST;
            proj_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW0:    row_reg[0] <= cfg_data;
                REG_ROW1:    row_reg[1] <= cfg_data;
                REG_ROW2:    row_reg[2] <= cfg_data;
                REG_ROW3:    row_reg[3] <= cfg_data;
                REG_PROJECT: proj_reg   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign vin[0] = vertex_x;
    assign vin[1] = vertex_y;
    assign vin[2] = vertex_z;
    assign vin[3] = vertex_w;

    // Valid bits of the matrix stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: all sixteen coefficient products.
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                p_reg[r][c] <= $signed(row_reg[r][COEF_W*c +: COEF_W]) * vin[c];
            end
        end

        // Stage 2: row sums in Q22.28.
        always_ff @(posedge clk)
        begin
            s_reg[r] <= {{2{p_reg[r][0][PROD_W-1]}}, p_reg[r][0]}
                      + {{2{p_reg[r][1][PROD_W-1]}}, p_reg[r][1]}
                      + {{2{p_reg[r][2][PROD_W-1]}}, p_reg[r][2]}
                      + {{2{p_reg[r][3][PROD_W-1]}}, p_reg[r][3]};
        end

        // Truncate the magnitude toward zero and clamp.
        logic [SUM_W-1:0] mag;
        always_comb
        begin
            mag   = s_reg[r][SUM_W-1] ? (~s_reg[r] + SUM_W'(1)) : s_reg[r];
            cp[r] = clamp_pack(s_reg[r][SUM_W-1],
                               DIV_BITS'(mag[SUM_W-1:FRAC_COEF]));
        end
    end

    // Stage 3: clamped row results and the projection decision.
    always_comb
    begin
        s3_next.tx   = cp[0][VERT_W-1:0];
        s3_next.ty   = cp[1][VERT_W-1:0];
        s3_next.tz   = cp[2][VERT_W-1:0];
        s3_next.tw   = cp[3][VERT_W-1:0];
        s3_next.sat  = cp[0][VERT_W] | cp[1][VERT_W] | cp[2][VERT_W] | cp[3][VERT_W];
        s3_next.skip = proj_reg & (cp[3][VERT_W-1:0] == '0);
        s3_next.div  = proj_reg & (cp[3][VERT_W-1:0] != '0);
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s3_next;
    end

    // Dividers for x and y share the saturated w as divisor.
    vtp_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (s3_reg.tx),
        .den       (s3_reg.tw),
        .out_valid (qx_valid),
        .quot      (qx),
        .sat       (qx_sat)
    );

    vtp_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (s3_reg.ty),
        .den       (s3_reg.tw),
        .out_valid (qy_valid),
        .quot      (qy),
        .sat       (qy_sat)
    );

    // Delay line that keeps the undivided results beside the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sv_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= s3_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Output register: pick quotients when dividing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg <= side_reg[DIV_LAT-1].div ? qx : side_reg[DIV_LAT-1].tx;
        out_y_reg <= side_reg[DIV_LAT-1].div ? qy : side_reg[DIV_LAT-1].ty;
        out_z_reg <= side_reg[DIV_LAT-1].tz;
        out_w_reg <= side_reg[DIV_LAT-1].tw;
        skip_reg  <= side_reg[DIV_LAT-1].skip;
        sat_reg   <= side_reg[DIV_LAT-1].sat
                   | (side_reg[DIV_LAT-1].div & (qx_sat | qy_sat));
    end

    assign done           = done_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign out_z          = out_z_reg;
    assign out_w          = out_w_reg;
    assign divide_skipped = skip_reg;
    assign saturated      = sat_reg;

`ifndef SYNTHESIS
    // A skipped divide only happens for a zero transformed w.
    a_skip_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_skipped |-> out_w == '0)
        else $error("divide skipped with nonzero w");

    // Divider outputs stay aligned with the delay line.
    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        qx_valid == sv_reg[DIV_LAT-1] && qy_valid == sv_reg[DIV_LAT-1])
        else $error("divider out of step with delay line");

    // Skip and divide never both apply to one transaction.
    a_skip_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !(s3_reg.skip && s3_reg.div))
        else $error("skip and divide both set");
`endif

endmodule
`default_nettype wire

// ===== tb/vertex_transform_project_core_tb.sv =====
// Self-checking testbench for the vertex transform core with optional perspective divide.
`timescale 1ns / 1ps
module vertex_transform_project_core_tb;
    import vtp_pkg::*;

    localparam int LATENCY   = 54;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic               skipped;
        logic               sat;
    } vertex_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [31:0]   vertex_x;
    logic signed [31:0]   vertex_y;
    logic signed [31:0]   vertex_z;
    logic signed [31:0]   vertex_w;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 done;
    logic signed [31:0]   out_x;
    logic signed [31:0]   out_y;
    logic signed [31:0]   out_z;
    logic signed [31:0]   out_w;
    logic                 divide_skipped;
    logic                 saturated;

    // Shadow copy of the matrix and the projection switch.
    logic [63:0]   shadow_rows [4];
    logic          shadow_project;

    vertex_t       pending_vertices[$];
    vertex_out_t   expected_vertices[$];
    int            error_count;
    int            cycle_count;
    logic          hold_sender;
    logic          calm_sender;

    vertex_transform_project_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z), .vertex_w(vertex_w),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .out_w(out_w), .divide_skipped(divide_skipped), .saturated(saturated)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Clamp a signed wide value to 32 bits, flagging saturation.
    function automatic logic [31:0] clamp32(input logic signed [127:0] val, inout logic sat);
        if (val > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (val < -128'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return val[31:0];
    endfunction

    // One matrix row applied to the vertex, truncated toward zero to Q16.16.
    function automatic logic [31:0] transform_row(input logic [63:0] row, input vertex_t v,
                                                  inout logic sat);
        logic signed [127:0] acc;
        logic signed [127:0] q;
        logic signed [31:0]  comp [4];
        comp[0] = v.x;
        comp[1] = v.y;
        comp[2] = v.z;
        comp[3] = v.w;
        acc = 0;
        for (int j = 0; j < 4; j++)
            acc += 128'(signed'(row[16*j +: 16])) * 128'(comp[j]);
        q = acc / 128'sd4096;
        return clamp32(q, sat);
    endfunction

    // Q16.16 quotient rounded toward zero.
    function automatic logic [31:0] project_div(input logic signed [31:0] num,
                                                input logic signed [31:0] den,
                                                inout logic sat);
        logic signed [127:0] q;
        q = (128'(num) * 128'sd65536) / 128'(den);
        return clamp32(q, sat);
    endfunction

    function automatic vertex_out_t transform_vertex(input vertex_t v);
        vertex_out_t r;
        logic        sat;
        sat = 1'b0;
        r.skipped = 1'b0;
        r.x = transform_row(shadow_rows[0], v, sat);
        r.y = transform_row(shadow_rows[1], v, sat);
        r.z = transform_row(shadow_rows[2], v, sat);
        r.w = transform_row(shadow_rows[3], v, sat);
        if (shadow_project) begin
            if (r.w == 0) begin
                r.skipped = 1'b1;
            end
            else begin
                r.x = project_div(r.x, r.w, sat);
                r.y = project_div(r.y, r.w, sat);
            end
        end
        r.sat = sat;
        return r;
    endfunction

    // Driver: one vertex transaction per accepted start.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy)
                expected_vertices.push_back(transform_vertex(
                    vertex_t'({vertex_x, vertex_y, vertex_z, vertex_w})));
            if ((!start || !busy) && pending_vertices.size() > 0 && !hold_sender
                    && (calm_sender || $urandom_range(99) >= 27)) begin
                vertex_t v;
                v = pending_vertices.pop_front();
                start    <= 1'b1;
                vertex_x <= v.x;
                vertex_y <= v.y;
                vertex_z <= v.z;
                vertex_w <= v.w;
            end
            else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected result out_x=%h", out_x);
                error_count++;
            end
            else begin
                vertex_out_t e;
                e = expected_vertices.pop_front();
                if (out_x !== e.x) begin
                    $error("out_x exp %h got %h", e.x, out_x);
                    error_count++;
                end
                if (out_y !== e.y) begin
                    $error("out_y exp %h got %h", e.y, out_y);
                    error_count++;
                end
                if (out_z !== e.z) begin
                    $error("out_z exp %h got %h", e.z, out_z);
                    error_count++;
                end
                if (out_w !== e.w) begin
                    $error("out_w exp %h got %h", e.w, out_w);
                    error_count++;
                end
                if (divide_skipped !== e.skipped) begin
                    $error("divide_skipped exp %b got %b", e.skipped, divide_skipped);
                    error_count++;
                end
                if (saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Wait until the pipeline has drained completely.
    task automatic drain_pipeline();
        while (pending_vertices.size() > 0 || start || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // One register write; valid drops for a cycle before the next write.
    task automatic write_register(input cfg_reg_t idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROW0:    shadow_rows[0] = data;
            REG_ROW1:    shadow_rows[1] = data;
            REG_ROW2:    shadow_rows[2] = data;
            REG_ROW3:    shadow_rows[3] = data;
            REG_PROJECT: shadow_project = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_component();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(4194304)) - 2097152);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1048576)) - 524288) <<< 4;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(4))
            0: return 16'($urandom());
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2: return 16'h0000;
            default: return 16'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    task automatic queue_random(input int count);
        vertex_t v;
        for (int i = 0; i < count; i++) begin
            v.x = rand_component();
            v.y = rand_component();
            v.z = rand_component();
            v.w = ($urandom_range(7) == 0) ? 32'sd0 : rand_component();
            pending_vertices.push_back(v);
        end
    endtask

    initial begin
        logic [63:0] row;
        error_count    = 0;
        cycle_count    = 0;
        hold_sender    = 1'b0;
        calm_sender    = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_ROW0;
        cfg_data       = 64'd0;
        vertex_x       = 0;
        vertex_y       = 0;
        vertex_z       = 0;
        vertex_w       = 0;
        shadow_rows[0] = ROW0_RST;
        shadow_rows[1] = ROW1_RST;
        shadow_rows[2] = ROW2_RST;
        shadow_rows[3] = ROW3_RST;
        shadow_project = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, extremes, zero w with projection on and off.
        pending_vertices.push_back(vertex_t'({32'sd0, 32'sd0, 32'sd0, 32'sd0}));
        pending_vertices.push_back(vertex_t'({32'h7FFF_FFFF, 32'h8000_0000,
                                              32'hFFFF_FFFF, 32'h0001_0000}));
        pending_vertices.push_back(vertex_t'({32'h0003_0000, 32'hFFFE_0000,
                                              32'h0001_8000, 32'h0002_0000}));
        drain_pipeline();
        write_register(REG_PROJECT, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_vertices.push_back(vertex_t'({32'h0005_0000, 32'h0007_0000,
                                              32'h1234_5678, 32'sd0}));
        pending_vertices.push_back(vertex_t'({32'h7FFF_FFFF, 32'h8000_0000,
                                              32'sd0, 32'sd1}));
        pending_vertices.push_back(vertex_t'({32'h8000_0000, 32'h0001_0000,
                                              32'sd0, 32'hFFFF_FFFF}));
        pending_vertices.push_back(vertex_t'({32'h0003_0000, 32'hFFFD_0000,
                                              32'sd0, 32'h8000_0000}));
        drain_pipeline();
        // Extreme matrix coefficients force row-sum overflow.
        write_register(REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_register(REG_ROW1, 64'h8000_8000_8000_8000);
        write_register(REG_ROW2, 64'h0000_0000_0000_0000);
        write_register(REG_ROW3, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_vertices.push_back(vertex_t'({32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 32'h7FFF_FFFF}));
        pending_vertices.push_back(vertex_t'({32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 32'h8000_0000}));
        pending_vertices.push_back(vertex_t'({32'sd1, 32'sd0, 32'sd0, 32'sd0}));
        drain_pipeline();

        // Random phases, fresh matrices (identity first); phase 1 has no random gaps.
        for (int phase = 0; phase < 8; phase++) begin
            for (int r = 0; r < 4; r++) begin
                row = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
                if (phase == 0)
                    row = 64'h1000 << (16 * r);
                write_register(cfg_reg_t'(r), row);
            end
            write_register(REG_PROJECT, 64'($urandom_range(1)));
            calm_sender = (phase == 1);
            queue_random(120);
            // Hold the sender until everything in flight has come back.
            while (pending_vertices.size() > 60) @(posedge clk);
            hold_sender = 1'b1;
            while (start || expected_vertices.size() > 0) @(posedge clk);
            hold_sender = 1'b0;
            queue_random(115);
            drain_pipeline();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== vertex_transform_project_core.f =====
hdl/vtp_pkg.sv
hdl/vtp_div.sv
hdl/vertex_transform_project_core.sv
tb/vertex_transform_project_core_tb.sv
